// File: src/lcmc_pkg.sv
package lcmc_pkg;

   // Field widths of the sample path and the calibration table.
   localparam int CountWidth  = 24;
   localparam int WeightWidth = 24;
   localparam int WideWidth   = 26;
   localparam int ProdWidth   = 2 * WeightWidth;
   localparam int CalPoints   = 4;
   localparam int MaxPoints   = 4;
   localparam int RegCount    = 8;

   typedef logic signed [CountWidth-1:0] count_type;
   typedef logic [WeightWidth-1:0]       weight_type;
   typedef logic signed [WideWidth-1:0]  wide_type;

   // Reset contents of the calibration table.
   localparam count_type CalCountReset [MaxPoints] = '{
      24'sd235469, 24'sd546061, 24'sd856428, 24'sd1477409
   };
   localparam weight_type CalWeightReset [MaxPoints] = '{
      24'd0, 24'd50000, 24'd100000, 24'd200000
   };

   // Operation codes carried in tuser of the request channel.
   typedef enum logic [2:0] {
      OP_SAMPLE     = 3'd0,
      OP_TARE       = 3'd1,
      OP_SET_OFFSET = 3'd2,
      OP_POWER_UP   = 3'd3,
      OP_POWER_DOWN = 3'd4
   } op_type;

   // Register indexes on the configuration port.
   typedef enum logic [2:0] {
      REG_COUNT_0  = 3'd0,
      REG_COUNT_1  = 3'd1,
      REG_COUNT_2  = 3'd2,
      REG_COUNT_3  = 3'd3,
      REG_WEIGHT_0 = 3'd4,
      REG_WEIGHT_1 = 3'd5,
      REG_WEIGHT_2 = 3'd6,
      REG_WEIGHT_3 = 3'd7
   } reg_type;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CORRECT,
      ST_SEGMENT,
      ST_MULTIPLY,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic load_corr;
      logic load_seg;
      logic load_prod;
      logic div_step;
      logic load_result;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic launch;
      logic skip;
      logic rsp_busy;
   } status_type;

endpackage

// File: src/lcmc_csr.sv
module lcmc_csr (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [4:0]            csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready,
   output lcmc_pkg::count_type   cal_count [lcmc_pkg::MaxPoints],
   output lcmc_pkg::weight_type  cal_weight [lcmc_pkg::MaxPoints]
);

   lcmc_pkg::count_type  count_ff  [lcmc_pkg::MaxPoints];
   lcmc_pkg::count_type  count_in  [lcmc_pkg::MaxPoints];
   lcmc_pkg::weight_type weight_ff [lcmc_pkg::MaxPoints];
   lcmc_pkg::weight_type weight_in [lcmc_pkg::MaxPoints];
   logic [2:0]           index;
   logic                 write_en;

   assign csr_pready = 1'b1;
   assign index      = csr_paddr[4:2];
   assign write_en   = csr_psel & csr_penable & csr_pwrite & csr_pready;

   // Decode a write transaction into the selected table entry.
   always_comb begin
      count_in  = count_ff;
      weight_in = weight_ff;
      if (write_en) begin
         if (index[2] == 1'b0) begin
            count_in[index[1:0]] = csr_pwdata[23:0];
         end else begin
            weight_in[index[1:0]] = csr_pwdata[23:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= lcmc_pkg::CalCountReset;
         weight_ff <= lcmc_pkg::CalWeightReset;
      end else begin
         count_ff  <= count_in;
         weight_ff <= weight_in;
      end
   end

   // Read back the addressed register, zero-extended.
   always_comb begin
      case (index)
         lcmc_pkg::REG_COUNT_0:  csr_prdata = {8'd0, count_ff[0]};
         lcmc_pkg::REG_COUNT_1:  csr_prdata = {8'd0, count_ff[1]};
         lcmc_pkg::REG_COUNT_2:  csr_prdata = {8'd0, count_ff[2]};
         lcmc_pkg::REG_COUNT_3:  csr_prdata = {8'd0, count_ff[3]};
         lcmc_pkg::REG_WEIGHT_0: csr_prdata = {8'd0, weight_ff[0]};
         lcmc_pkg::REG_WEIGHT_1: csr_prdata = {8'd0, weight_ff[1]};
         lcmc_pkg::REG_WEIGHT_2: csr_prdata = {8'd0, weight_ff[2]};
         lcmc_pkg::REG_WEIGHT_3: csr_prdata = {8'd0, weight_ff[3]};
         default:                csr_prdata = 32'd0;
      endcase
   end

   assign cal_count  = count_ff;
   assign cal_weight = weight_ff;

endmodule

// File: src/lcmc_ctrl.sv
module lcmc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  lcmc_pkg::status_type   status,
   output lcmc_pkg::cmd_type      cmd
);

   lcmc_pkg::state_type state_ff;
   lcmc_pkg::state_type state_in;
   logic [4:0]          cnt_ff;
   logic [4:0]          cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lcmc_pkg::ST_IDLE;
         cnt_ff   <= 5'd0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Next state and datapath commands.
   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         lcmc_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               if (status.launch) begin
                  state_in = lcmc_pkg::ST_CORRECT;
               end
            end
         end
         lcmc_pkg::ST_CORRECT: begin
            cmd.load_corr = 1'b1;
            state_in      = lcmc_pkg::ST_SEGMENT;
         end
         lcmc_pkg::ST_SEGMENT: begin
            cmd.load_seg = 1'b1;
            state_in     = lcmc_pkg::ST_MULTIPLY;
         end
         lcmc_pkg::ST_MULTIPLY: begin
            cmd.load_prod = 1'b1;
            cnt_in        = 5'd0;
            state_in      = status.skip ? lcmc_pkg::ST_FINISH : lcmc_pkg::ST_DIVIDE;
         end
         lcmc_pkg::ST_DIVIDE: begin
            // One quotient bit per cycle.
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 5'd1;
            if (cnt_ff == 5'(lcmc_pkg::WeightWidth - 1)) begin
               state_in = lcmc_pkg::ST_FINISH;
            end
         end
         lcmc_pkg::ST_FINISH: begin
            if (!status.rsp_busy) begin
               cmd.load_result = 1'b1;
               state_in        = lcmc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lcmc_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// File: src/lcmc_dp.sv
module lcmc_dp #(
   parameter int CAL_POINTS = lcmc_pkg::CalPoints
) (
   input  logic                  clock,
   input  logic                  reset,
   input  lcmc_pkg::cmd_type     cmd,
   output lcmc_pkg::status_type  status,
   input  logic [2:0]            req_opcode,
   input  lcmc_pkg::count_type   req_sample,
   input  lcmc_pkg::count_type   req_offset,
   input  lcmc_pkg::count_type   cal_count [lcmc_pkg::MaxPoints],
   input  lcmc_pkg::weight_type  cal_weight [lcmc_pkg::MaxPoints],
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output lcmc_pkg::weight_type  rsp_weight,
   output logic                  rsp_oor
);

   localparam int W  = lcmc_pkg::WeightWidth;
   localparam int PW = lcmc_pkg::ProdWidth;

   // Architectural state.
   lcmc_pkg::count_type  window_ff [3];
   logic [1:0]           fill_ff;
   lcmc_pkg::count_type  tare_ff;
   logic                 powered_ff;

   // Work registers of one conversion.
   lcmc_pkg::wide_type   corr_ff;
   logic [W-1:0]         dx_ff;
   logic [W-1:0]         cx_ff;
   logic [W-1:0]         mag_ff;
   logic                 neg_ff;
   logic                 skip_ff;
   logic                 oor_ff;
   lcmc_pkg::weight_type base_ff;
   logic [W-1:0]         rem_ff;
   logic [W-1:0]         quo_ff;

   // Output register.
   logic                 rsp_valid_ff;
   lcmc_pkg::weight_type rsp_weight_ff;
   logic                 rsp_oor_ff;

   // Next values.
   logic                 rsp_valid_in;
   lcmc_pkg::wide_type   corr_in;
   logic [W-1:0]         rem_in;
   logic [W-1:0]         quo_in;
   lcmc_pkg::weight_type result_in;

   lcmc_pkg::count_type  lo;
   lcmc_pkg::count_type  hi;
   lcmc_pkg::count_type  mid;
   lcmc_pkg::count_type  median;
   logic                 full;
   logic                 is_sample;

   lcmc_pkg::wide_type   xw [lcmc_pkg::MaxPoints];
   logic                 hit;
   logic [1:0]           seg;
   logic [1:0]           seg_next;
   lcmc_pkg::wide_type   dx_w;
   lcmc_pkg::wide_type   cx_w;
   logic [PW-1:0]        prod;
   logic [W:0]           shifted;
   logic [W:0]           trial;

   // Median of three from the window.
   always_comb begin
      lo     = (window_ff[0] < window_ff[1]) ? window_ff[0] : window_ff[1];
      hi     = (window_ff[0] < window_ff[1]) ? window_ff[1] : window_ff[0];
      mid    = (hi < window_ff[2]) ? hi : window_ff[2];
      median = (lo > mid) ? lo : mid;
   end

   assign full      = (fill_ff == 2'd3);
   assign is_sample = (req_opcode == lcmc_pkg::OP_SAMPLE);

   // A sample that leaves the window full yields a result.
   assign status.launch   = is_sample & powered_ff & (fill_ff[1] == 1'b1);
   assign status.skip     = skip_ff;
   assign status.rsp_busy = rsp_valid_ff & ~rsp_tready;

   // Window, fill count, tare and power flag follow each accepted transaction.
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff    <= 2'd0;
         tare_ff    <= '0;
         powered_ff <= 1'b0;
      end else if (cmd.accept) begin
         case (req_opcode)
            lcmc_pkg::OP_SAMPLE: begin
               if (powered_ff && !full) begin
                  fill_ff <= fill_ff + 2'd1;
               end
            end
            lcmc_pkg::OP_TARE: begin
               if (full) begin
                  tare_ff <= median;
               end
            end
            lcmc_pkg::OP_SET_OFFSET: begin
               tare_ff <= req_offset;
            end
            lcmc_pkg::OP_POWER_UP: begin
               if (!powered_ff) begin
                  fill_ff    <= 2'd0;
                  powered_ff <= 1'b1;
               end
            end
            lcmc_pkg::OP_POWER_DOWN: begin
               powered_ff <= 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   // Window storage: fill in order, then slide.
   always_ff @(posedge clock) begin
      if (cmd.accept && is_sample && powered_ff) begin
         if (full) begin
            window_ff[0] <= window_ff[1];
            window_ff[1] <= window_ff[2];
            window_ff[2] <= req_sample;
         end else begin
            window_ff[fill_ff] <= req_sample;
         end
      end
   end

   // Corrected count: median less tare plus the zero reference.
   assign corr_in = lcmc_pkg::wide_type'(median) - lcmc_pkg::wide_type'(tare_ff)
                    + lcmc_pkg::wide_type'(cal_count[0]);

   // Segment search; the lowest matching segment wins.
   always_comb begin
      for (int i = 0; i < lcmc_pkg::MaxPoints; i++) begin
         xw[i] = lcmc_pkg::wide_type'(cal_count[i]);
      end
      hit = 1'b0;
      seg = 2'd0;
      for (int i = CAL_POINTS - 2; i >= 0; i--) begin
         if (corr_ff >= xw[i] && corr_ff <= xw[i+1]) begin
            hit = 1'b1;
            seg = 2'(i);
         end
      end
      seg_next = seg + 2'd1;
      dx_w     = xw[seg_next] - xw[seg];
      cx_w     = corr_ff - xw[seg];
   end

   // Unsigned product of weight span and count distance.
   assign prod = PW'(mag_ff) * PW'(cx_ff);

   // Restoring division step.
   always_comb begin
      shifted = {rem_ff, quo_ff[W-1]};
      trial   = shifted - {1'b0, dx_ff};
      if (shifted >= {1'b0, dx_ff}) begin
         rem_in = trial[W-1:0];
         quo_in = {quo_ff[W-2:0], 1'b1};
      end else begin
         rem_in = shifted[W-1:0];
         quo_in = {quo_ff[W-2:0], 1'b0};
      end
   end

   // Final weight from the segment base and the signed quotient.
   always_comb begin
      if (skip_ff) begin
         result_in = base_ff;
      end else if (neg_ff) begin
         result_in = base_ff - quo_ff;
      end else begin
         result_in = base_ff + quo_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_corr) begin
         corr_ff <= corr_in;
      end
      if (cmd.load_seg) begin
         dx_ff   <= dx_w[W-1:0];
         cx_ff   <= cx_w[W-1:0];
         neg_ff  <= cal_weight[seg_next] < cal_weight[seg];
         mag_ff  <= (cal_weight[seg_next] < cal_weight[seg]) ?
                    cal_weight[seg] - cal_weight[seg_next] :
                    cal_weight[seg_next] - cal_weight[seg];
         skip_ff <= ~hit | (dx_w == '0);
         oor_ff  <= ~hit;
         if (hit) begin
            base_ff <= cal_weight[seg];
         end else if (corr_ff < xw[0]) begin
            base_ff <= cal_weight[0];
         end else begin
            base_ff <= cal_weight[CAL_POINTS-1];
         end
      end
      if (cmd.load_prod) begin
         rem_ff <= prod[PW-1:W];
         quo_ff <= prod[W-1:0];
      end else if (cmd.div_step) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   // Result register, released by the result transaction.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load_result) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_result) begin
         rsp_weight_ff <= result_in;
         rsp_oor_ff    <= oor_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_weight = rsp_weight_ff;
   assign rsp_oor    = rsp_oor_ff;

endmodule

// File: src/load_cell_median_calibrate.sv
// Load-cell front end: each sample transaction (opcode 0 in tuser) taken
// while powered up enters a window of three; once the window is full every
// sample returns one result, the median corrected by the tare offset and the
// zero reference, mapped to milligrams by linear interpolation over
// CAL_POINTS calibration points (four by default) from the register port.
// Tare capture, direct offset, power up and power down give no result. A
// sample that yields a result passes the correct, segment and multiply
// states, the 24 steps of the one-bit-per-cycle divider and the finish state
// on its way to the result register; the block takes the next request in
// the cycle after the result is loaded. A clamped count or one on a
// zero-width segment skips the divider. Other transactions leave the
// controller idle. The next request is accepted while a finished result
// still waits on the result channel; a later result then holds in its last
// step until the earlier one has been taken.
module load_cell_median_calibrate #(
   parameter int CAL_POINTS = lcmc_pkg::CalPoints
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // [23:0] sample, [47:24] offset_value
   input  logic [2:0]  req_tuser,   // [2:0] opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [23:0] weight_mg
   output logic        rsp_tuser,   // [0] out_of_range
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   lcmc_pkg::count_type  cal_count  [lcmc_pkg::MaxPoints];
   lcmc_pkg::weight_type cal_weight [lcmc_pkg::MaxPoints];
   lcmc_pkg::cmd_type    cmd;
   lcmc_pkg::status_type status;

   // Calibration table registers.
   lcmc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cal_count   (cal_count),
      .cal_weight  (cal_weight)
   );

   // Sequencer.
   lcmc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // Window, correction, interpolation and result register.
   lcmc_dp #(
      .CAL_POINTS (CAL_POINTS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_opcode (req_tuser),
      .req_sample (req_tdata[23:0]),
      .req_offset (req_tdata[47:24]),
      .cal_count  (cal_count),
      .cal_weight (cal_weight),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_weight (rsp_tdata),
      .rsp_oor    (rsp_tuser)
   );

endmodule
